[rtl/rectangle_record_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Rectangle record encoder assertion macros
// Concurrent checks on clk with rst_n as the disable; empty when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_RECORD_ENCODER_MACROS_SVH
`define RECTANGLE_RECORD_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RRE_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rre: same-cycle check failed");

// next-cycle implication
`define RRE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rre: next-cycle check failed");

`else

`define RRE_ASSERT_IMPL(label, pre, post)
`define RRE_ASSERT_NEXT(label, pre, post)

`endif

`endif

[rtl/rre_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle record encoder package
// Shared constants and the command type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package rre_pkg;

    localparam logic [7:0] RECORD_ID   = 8'h14;
    localparam logic [7:0] INFO_SQUARE = 8'hDB;  // S W X Y D L
    localparam logic [7:0] INFO_RECT   = 8'h7B;  // W H X Y D L
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    localparam int QUEUE_DEPTH = 2;

    // One classified rectangle: sizes as is, coordinates already zigzagged
    // (magnitude << 1 | sign), which needs 32 bits for -2^30.
    typedef struct packed {
        logic        square;
        logic [30:0] width;
        logic [30:0] height;
        logic [31:0] x_code;
        logic [31:0] y_code;
    } rre_cmd_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic     valid;
        rre_cmd_t cmd;
    } rre_head_t;

endpackage

`default_nettype wire

[rtl/rre_if.sv]
// ----------------------------------------------------------------------------
// Rectangle record encoder channels
// Valid/ready interfaces for the rectangle input and the byte output.
// ----------------------------------------------------------------------------
`default_nettype none

interface rre_rect_if;
    logic               valid;
    logic               ready;
    logic        [30:0] rect_width;
    logic        [30:0] rect_height;
    logic signed [30:0] left_x;
    logic signed [30:0] lower_y;

    modport source (output valid, output rect_width, output rect_height,
                    output left_x, output lower_y, input ready);
    modport sink   (input valid, input rect_width, input rect_height,
                    input left_x, input lower_y, output ready);
endinterface

interface rre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/rre_front.sv]
// ----------------------------------------------------------------------------
// Rectangle record encoder front end
// Accepts rectangles, flags squares and zigzags the coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module rre_front
(
    rre_rect_if.sink          rect,
    input  wire logic         full,
    output rre_pkg::rre_cmd_t cmd,
    output logic              push
);

    logic [30:0] x_mag;
    logic [30:0] y_mag;

    always_comb
    begin
        rect.ready = !full;
        push       = rect.valid && !full;

        // 31-bit negate; -2^30 gives magnitude 2^30
        x_mag = rect.left_x[30]  ? (~rect.left_x  + 31'd1) : rect.left_x;
        y_mag = rect.lower_y[30] ? (~rect.lower_y + 31'd1) : rect.lower_y;

        cmd.square = (rect.rect_width == rect.rect_height);
        cmd.width  = rect.rect_width;
        cmd.height = rect.rect_height;
        cmd.x_code = {x_mag, rect.left_x[30]};
        cmd.y_code = {y_mag, rect.lower_y[30]};
    end

endmodule

`default_nettype wire

[rtl/rre_queue.sv]
// ----------------------------------------------------------------------------
// Rectangle record encoder command queue
// Small FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_record_encoder_macros.svh"

module rre_queue
#(
    parameter int DEPTH = rre_pkg::QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rre_pkg::rre_cmd_t  push_cmd,
    input  wire logic               pop,
    output logic                    full,
    output rre_pkg::rre_head_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rre_pkg::rre_cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        head.valid = (count_reg != '0);
        head.cmd   = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `RRE_ASSERT_IMPL(a_no_overflow, push, count_reg != CNT_W'(DEPTH))
    `RRE_ASSERT_IMPL(a_no_underflow, pop, count_reg != '0)
    `RRE_ASSERT_IMPL(a_empty_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

[rtl/rre_back.sv]
// ----------------------------------------------------------------------------
// Rectangle record encoder back end
// Byte sequencer: header, then varints seven bits per cycle unless the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectangle_record_encoder_macros.svh"

module rre_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rre_pkg::rre_head_t head,
    output logic                    pop,
    rre_byte_if.source              code_bytes
);

    localparam logic [2:0] PH_ID    = 3'd0;
    localparam logic [2:0] PH_INFO  = 3'd1;
    localparam logic [2:0] PH_LAYER = 3'd2;
    localparam logic [2:0] PH_DTYPE = 3'd3;
    localparam logic [2:0] PH_W     = 3'd4;
    localparam logic [2:0] PH_H     = 3'd5;
    localparam logic [2:0] PH_X     = 3'd6;
    localparam logic [2:0] PH_Y     = 3'd7;

    logic        busy_reg,   busy_next;
    logic [2:0]  phase_reg,  phase_next;
    logic        square_reg, square_next;
    logic [30:0] height_reg, height_next;
    logic [31:0] x_reg,      x_next;
    logic [31:0] y_reg,      y_next;
    logic [31:0] cur_reg,    cur_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_last_reg,  out_last_next;

    logic        advance;
    logic        more;
    logic        last;
    logic [7:0]  cur_byte;

    always_comb
    begin
        advance = busy_reg && (!out_valid_reg || code_bytes.ready);
        more    = (phase_reg >= PH_W) && (cur_reg[31:7] != '0);
        last    = (phase_reg == PH_Y) && !more;
        pop     = head.valid && (!busy_reg || (advance && last));

        case (phase_reg)
            PH_ID:    cur_byte = rre_pkg::RECORD_ID;
            PH_INFO:  cur_byte = square_reg ? rre_pkg::INFO_SQUARE : rre_pkg::INFO_RECT;
            PH_LAYER: cur_byte = rre_pkg::ZERO_BYTE;
            PH_DTYPE: cur_byte = rre_pkg::ZERO_BYTE;
            default:  cur_byte = {more, cur_reg[6:0]};
        endcase

        busy_next   = busy_reg;
        phase_next  = phase_reg;
        square_next = square_reg;
        height_next = height_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        cur_next    = cur_reg;

        if (advance)
        begin
            if (more)
            begin
                cur_next = {7'd0, cur_reg[31:7]};
            end
            else
            begin
                case (phase_reg)
                    PH_ID:    phase_next = PH_INFO;
                    PH_INFO:  phase_next = PH_LAYER;
                    PH_LAYER: phase_next = PH_DTYPE;
                    PH_DTYPE: phase_next = PH_W;
                    PH_W:
                    begin
                        // square: height is left out
                        phase_next = square_reg ? PH_X : PH_H;
                        cur_next   = square_reg ? x_reg : {1'b0, height_reg};
                    end
                    PH_H:
                    begin
                        phase_next = PH_X;
                        cur_next   = x_reg;
                    end
                    PH_X:
                    begin
                        phase_next = PH_Y;
                        cur_next   = y_reg;
                    end
                    default:
                    begin
                        phase_next = PH_ID;
                        busy_next  = 1'b0;
                    end
                endcase
            end
        end

        if (pop)
        begin
            busy_next   = 1'b1;
            phase_next  = PH_ID;
            square_next = head.cmd.square;
            height_next = head.cmd.height;
            x_next      = head.cmd.x_code;
            y_next      = head.cmd.y_code;
            cur_next    = {1'b0, head.cmd.width};
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = last;
        end
        else if (code_bytes.ready)
        begin
            out_valid_next = 1'b0;
        end

        code_bytes.valid     = out_valid_reg;
        code_bytes.out_byte  = out_byte_reg;
        code_bytes.last_byte = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_ID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        square_reg   <= square_next;
        height_reg   <= height_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    `RRE_ASSERT_IMPL(a_last_no_cont, out_valid_reg && out_last_reg, !out_byte_reg[7])
    `RRE_ASSERT_IMPL(a_idle_phase, !busy_reg, phase_reg == PH_ID)
    `RRE_ASSERT_NEXT(a_pop_starts, pop, busy_reg && (phase_reg == PH_ID))

endmodule

`default_nettype wire

[rtl/rectangle_record_encoder.sv]
// ----------------------------------------------------------------------------
// Rectangle record encoder
// Turns one rectangle into its layout-format record, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   rect       : valid/ready input, one rectangle (width, height, left x,
//                lower y) per item.
//   code_bytes : valid/ready output, one record byte per item; last_byte
//                marks the final byte of each record.
//   Record: id 0x14, info byte, two zero bytes, width varint, height varint
//   (left out for a square), zigzag x and y varints. 7 to 24 bytes.
//   When the sequencer is idle, a taken rectangle goes into the queue, is
//   popped into the sequencer, and its first byte is registered at the output.
//   Throughput: one byte per cycle from the back-end sequencer while the sink
//   is ready; records follow without a gap when the next one is queued.
//   The front classifies and queues rectangles (queue depth QUEUE_DEPTH),
//   so input keeps flowing while the sequencer is busy or the sink stalls.
//   Reset clears the queue, the sequencer and the output register; no
//   partial record survives. A stalled sink holds the current byte and the
//   sequencer waits; once the queue fills, rect.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_record_encoder
#(
    parameter int QUEUE_DEPTH = rre_pkg::QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rre_rect_if.sink   rect,
    rre_byte_if.source code_bytes
);

    rre_pkg::rre_cmd_t  front_cmd;
    rre_pkg::rre_head_t q_head;
    logic               q_push;
    logic               q_pop;
    logic               q_full;

    // classify: square flag and zigzag coordinates
    rre_front u_front
    (
        .rect (rect),
        .full (q_full),
        .cmd  (front_cmd),
        .push (q_push)
    );

    // decouples intake from byte emission
    rre_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .head     (q_head)
    );

    // byte sequencer with output register
    rre_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .pop        (q_pop),
        .code_bytes (code_bytes)
    );

endmodule

`default_nettype wire

[sim/rectangle_record_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle record encoder testbench
// Sends rectangles in random bursts into the encoder and checks every record
// byte against a predicted byte stream. A short table of corner cases runs
// first, then random rectangles, while the byte sink stalls on its own
// pattern.
// ----------------------------------------------------------------------------

module rectangle_record_encoder_tb;

    // ------------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------------
    localparam int N_DIRECTED  = 17;
    localparam int N_RANDOM    = 450;
    // Worst case is about 470 items x 24 bytes, each byte held by the longest
    // sink stall, so CYCLE_LIMIT leaves plenty of headroom.
    localparam int CYCLE_LIMIT = 1500000;
    // First byte shows up once the rectangle has passed the queue and the
    // sequencer; wait a good deal longer than that for stray bytes at the end.
    localparam int DRAIN_CYCLES = 64;

    // One record byte as seen on the output channel.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } record_byte_t;

    // One stimulus row. n_gold != 0 means the record bytes are typed in
    // (right-justified in gold, first byte most significant); otherwise the
    // expected record comes from the encoder model below.
    typedef struct packed {
        logic        [30:0]  width;
        logic        [30:0]  height;
        logic signed [30:0]  x;
        logic signed [30:0]  y;
        logic        [4:0]   n_gold;
        logic        [191:0] gold;
    } rect_row_t;

    logic clk;
    logic rst_n;

    rre_rect_if rect_ch ();
    rre_byte_if byte_ch ();

    rectangle_record_encoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rect       (rect_ch),
        .code_bytes (byte_ch)
    );

    // Bytes still owed by the encoder, oldest first.
    record_byte_t pending_bytes [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    // ------------------------------------------------------------------------
    // Directed table: zero values, single-byte and multi-byte varint edges,
    // squares (height dropped), full 31-bit sizes, the coordinate range
    // edges, the most negative coordinate and alternating bit patterns.
    // ------------------------------------------------------------------------
    rect_row_t directed_rows [N_DIRECTED] = '{
        // all zero: a square, every varint is a lone 0x00
        '{31'd0, 31'd0, 31'sd0, 31'sd0, 5'd7, 192'h14DB0000_00_00_00},
        // width 1, height 0: not square, height 0 still sent
        '{31'd1, 31'd0, 31'sd0, 31'sd0, 5'd8, 192'h147B0000_01_00_00_00},
        // one-byte max width, first two-byte height
        '{31'd127, 31'd128, 31'sd0, 31'sd0, 5'd9, 192'h147B0000_7F_8001_00_00},
        // small square, +1 and -1 coordinates
        '{31'd5, 31'd5, 31'sd1, -31'sd1, 5'd7, 192'h14DB0000_05_02_03},
        // longest record: full sizes, coordinates at the stated range ends
        '{31'h7FFFFFFF, 31'h7FFFFFFE, 31'sd1073741823, -31'sd1073741823, 5'd24,
          192'h147B0000_FFFFFFFF07_FEFFFFFF07_FEFFFFFF07_FFFFFFFF07},
        // most negative coordinate on both axes
        '{31'd3, 31'd3, 31'sh40000000, 31'sh40000000, 5'd15,
          192'h14DB0000_03_8180808008_8180808008},
        // full-width square
        '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'sd0, 31'sd0, 5'd11,
          192'h14DB0000_FFFFFFFF07_00_00},
        // zero width, full height
        '{31'd0, 31'h7FFFFFFF, 31'sd0, 31'sd0, 5'd12,
          192'h147B0000_00_FFFFFFFF07_00_00},
        // rows below are checked against the model
        '{31'd128, 31'd16383, 31'sd63, 31'sd64, 5'd0, '0},
        '{31'd16384, 31'd2097151, -31'sd64, -31'sd65, 5'd0, '0},
        '{31'd2097152, 31'd268435455, 31'sd8191, -31'sd8192, 5'd0, '0},
        '{31'd268435456, 31'd1, 31'sd8192, -31'sd8193, 5'd0, '0},
        '{31'd42, 31'd42, -31'sd1073741823, 31'sd1073741823, 5'd0, '0},
        '{31'd1000, 31'd999, -31'sd1, 31'sd0, 5'd0, '0},
        '{31'h55555555, 31'h2AAAAAAA, 31'sh2AAAAAAA, 31'sh55555555, 5'd0, '0},
        '{31'd1, 31'd2, 31'sd1073741823, 31'sd1073741823, 5'd0, '0},
        '{31'd2, 31'd1, -31'sd1073741823, 31'sd0, 5'd0, '0}
    };

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // Append one owed byte at the tail of the queue.
    function automatic void owe_byte(input logic [7:0] code, input logic last);
        record_byte_t b;
        b.code = code;
        b.last = last;
        pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    // Coordinate to unsigned code: magnitude in the upper bits, sign in bit 0.
    // -2^30 has magnitude 2^30, which lands on bit 31 after the shift.
    function automatic logic [63:0] zigzag(input logic signed [30:0] coord);
        logic [30:0] mag;
        mag = coord[30] ? (~coord + 31'd1) : coord;
        return {32'd0, mag, coord[30]};
    endfunction

    // Base-128, low group first, bit 7 set while more groups follow.
    function automatic void push_varint(input logic [63:0] value);
        logic [6:0] group;
        do
        begin
            group = value[6:0];
            value = value >> 7;
            owe_byte({(value != 0), group}, 1'b0);
        end
        while (value != 0);
    endfunction

    function automatic void encode_rectangle(input rect_row_t row);
        logic square;
        square = (row.width == row.height);
        owe_byte(rre_pkg::RECORD_ID, 1'b0);
        owe_byte(square ? rre_pkg::INFO_SQUARE : rre_pkg::INFO_RECT, 1'b0);
        owe_byte(rre_pkg::ZERO_BYTE, 1'b0);  // layer
        owe_byte(rre_pkg::ZERO_BYTE, 1'b0);  // datatype
        push_varint({33'd0, row.width});
        if (!square)
        begin
            push_varint({33'd0, row.height});
        end
        push_varint(zigzag(row.x));
        push_varint(zigzag(row.y));
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    // Typed-in record from the directed table.
    function automatic void push_golden(input rect_row_t row);
        int n;
        n = row.n_gold;
        for (int k = 0; k < n; k++)
        begin
            owe_byte(row.gold[8 * (n - 1 - k) +: 8], (k == n - 1));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random rectangles
    // ------------------------------------------------------------------------

    // Random bit length first so every varint length shows up often.
    function automatic logic [30:0] rand_size();
        int          nbits;
        logic [31:0] raw;
        logic [31:0] mask;
        nbits = $urandom_range(0, 31);
        raw   = $urandom;
        mask  = (32'd1 << nbits) - 32'd1;
        return raw[30:0] & mask[30:0];
    endfunction

    // Mostly sign plus sized magnitude; sometimes any 31-bit pattern, and
    // now and then the most negative value on purpose.
    function automatic logic signed [30:0] rand_coord();
        int          nbits;
        logic [31:0] raw;
        logic [31:0] mask;
        logic [30:0] mag;
        nbits = $urandom_range(0, 31);
        raw   = $urandom;
        if ($urandom_range(0, 63) == 0)
        begin
            return 31'sh40000000;
        end
        if (nbits == 31)
        begin
            return raw[30:0];
        end
        mask = (32'd1 << nbits) - 32'd1;
        mag  = raw[30:0] & mask[30:0];
        return raw[31] ? (~mag + 31'd1) : mag;
    endfunction

    function automatic rect_row_t rand_rect();
        rect_row_t row;
        row.width  = rand_size();
        // about one in five is a square
        row.height = ($urandom_range(0, 4) == 0) ? row.width : rand_size();
        row.x      = rand_coord();
        row.y      = rand_coord();
        row.n_gold = '0;
        row.gold   = '0;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Rectangle source
    // ------------------------------------------------------------------------

    // Present one rectangle and hold it until the encoder takes it. Returns
    // in the time step of the accepting edge, so the caller's next drive
    // lands right after that edge.
    task automatic send_rect(input rect_row_t row);
        rect_ch.valid       <= 1'b1;
        rect_ch.rect_width  <= row.width;
        rect_ch.rect_height <= row.height;
        rect_ch.left_x      <= row.x;
        rect_ch.lower_y     <= row.y;
        do
        begin
            @(posedge clk);
        end
        while (!rect_ch.ready);
        if (row.n_gold != 0)
        begin
            push_golden(row);
        end
        else
        begin
            encode_rectangle(row);
        end
    endtask

    initial
    begin : rect_source
        rect_row_t row;
        int        burst_left;
        int        gap;

        rect_ch.valid       <= 1'b0;
        rect_ch.rect_width  <= '0;
        rect_ch.rect_height <= '0;
        rect_ch.left_x      <= '0;
        rect_ch.lower_y     <= '0;
        burst_left = 1;

        wait (rst_n === 1'b1);
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED + N_RANDOM; i++)
        begin
            row = (i < N_DIRECTED) ? directed_rows[i] : rand_rect();
            send_rect(row);
            burst_left--;

            if (i == N_DIRECTED + 200 || i == N_DIRECTED + 350)
            begin
                // hold off until the encoder has fully drained
                rect_ch.valid <= 1'b0;
                while (pending_bytes.size() != 0)
                begin
                    @(posedge clk);
                end
                @(posedge clk);
            end
            else if (burst_left <= 0)
            begin
                // mostly short bursts; sometimes a long run with no gaps
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
                gap = $urandom_range(0, 8);
                if (gap > 0)
                begin
                    rect_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        rect_ch.valid <= 1'b0;

        // End of run: everything owed must arrive, then nothing more.
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_bytes.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte sink: stalls on a pattern that changes after a random span of cycles.
    //   mode 0 - always ready
    //   mode 1 - ready half the time
    //   mode 2 - ready a quarter of the time on average
    //   mode 3 - stall runs of random length between single ready cycles
    // ------------------------------------------------------------------------
    initial
    begin : byte_sink
        int mode;
        int span;
        int hold;

        byte_ch.ready <= 1'b0;
        hold = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: byte_ch.ready <= 1'b1;
                    1: byte_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: byte_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            byte_ch.ready <= 1'b0;
                            hold--;
                        end
                        else
                        begin
                            byte_ch.ready <= 1'b1;
                            hold = $urandom_range(0, 20);
                        end
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte checker: every accepted byte against the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_checker
        record_byte_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got %02h last %0b",
                         $realtime, byte_ch.out_byte, byte_ch.last_byte);
                mismatch_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_ch.out_byte !== want.code)
                begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $realtime, want.code, byte_ch.out_byte);
                    mismatch_count++;
                end
                if (byte_ch.last_byte !== want.last)
                begin
                    $display("%0t: last_byte mismatch: expected %0b, got %0b",
                             $realtime, want.last, byte_ch.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
